### rtl/gwpi_pkg.sv
// ----------------------------------------------------------------------------
// gwpi_pkg
// Shared GF(2^8) arithmetic helpers for the word polynomial inverse pipeline.
// ----------------------------------------------------------------------------
package gwpi_pkg;

  localparam int unsigned WordW = 32;
  localparam logic [7:0] GfPoly = 8'h1b;

  // Multiply two field elements with the AES reduction polynomial.
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] aa;
    acc = 8'h00;
    aa  = a;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) acc = acc ^ aa;
      aa = aa[7] ? ((aa << 1) ^ GfPoly) : (aa << 1);
    end
    return acc;
  endfunction

  // Inverse as a^254 built at elaboration into a constant lookup.
  function automatic logic [7:0] gf_inv_calc(input logic [7:0] a);
    logic [7:0] r;
    logic [7:0] bs;
    r  = 8'h01;
    bs = a;
    for (int k = 1; k < 8; k++) begin
      bs = gf_mul(bs, bs);
      r  = gf_mul(r, bs);
    end
    return r;
  endfunction

  typedef logic [7:0] inv_tab_t [256];

  function automatic inv_tab_t build_inv();
    inv_tab_t t;
    for (int i = 0; i < 256; i++) t[i] = gf_inv_calc(8'(i));
    return t;
  endfunction

  localparam inv_tab_t InvTab = build_inv();

  function automatic logic [7:0] gf_inv(input logic [7:0] a);
    return InvTab[a];
  endfunction

  // d = (0,0,qx,q1) * prev mod x^4+1, xor older. Index 0 of a word is x^3.
  function automatic logic [31:0] aux_next(input logic [7:0] qx, input logic [7:0] q1,
                                           input logic [31:0] prev,
                                           input logic [31:0] older);
    logic [7:0] p [4];
    logic [7:0] d [4];
    for (int i = 0; i < 4; i++) p[i] = prev[31-8*i -: 8];
    for (int i = 0; i < 4; i++) begin
      // qx sits at index 2, q1 at index 3: target (i+j+1)&3
      d[i] = gf_mul(qx, p[(i + 1) & 3]) ^ gf_mul(q1, p[i]) ^ older[31-8*i -: 8];
    end
    return {d[0], d[1], d[2], d[3]};
  endfunction

endpackage

### rtl/gf256_word_poly_inverse.sv
// ----------------------------------------------------------------------------
// gf256_word_poly_inverse
// Throughput is one beat per cycle while the output beat is not stalled.
// Each pipeline stage holds at most one table inverse and up to four chained
// multiply layers.
// Reset clears the stage valid bits; payload registers are not reset.
// A stall holds every stage at once, so no beat is lost or repeated.
// ----------------------------------------------------------------------------
module gf256_word_poly_inverse (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] poly_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] inverse_word_o,
  output logic        invertible_o
);
  import gwpi_pkg::*;

  localparam int unsigned NStg = 6;

  // Global enable: the whole pipe advances unless the output beat is stuck.
  logic adv;
  assign adv = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  logic [NStg-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NStg-2:0], in_valid_i};
    end
  end

  // Stage 1: round one.
  logic [7:0] rb_q [5];
  logic [7:0] rc_q [5];
  logic [31:0] xc_q;
  logic ok1_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      logic [7:0] qa, qb;
      logic [7:0] rb [5];
      logic [7:0] ra [5];
      logic [7:0] t [5];
      rb[0] = 8'h00;
      for (int i = 1; i < 5; i++) rb[i] = poly_word_i[39-8*i -: 8];
      ra = '{8'h01, 8'h00, 8'h00, 8'h00, 8'h01};
      qa = gf_inv(rb[1]);
      for (int i = 0; i < 4; i++) t[i] = gf_mul(qa, rb[i+1]) ^ ra[i];
      t[4] = ra[4];
      qb = gf_mul(qa, t[1]);
      for (int i = 0; i < 5; i++) rc_q[i] <= t[i] ^ gf_mul(qb, rb[i]);
      rb_q <= rb;
      xc_q <= {16'h0000, qa, qb};
      ok1_q <= 1'b1;
    end
  end

  // Stage 2: round two remainder.
  logic [7:0] rc2_q [5];
  logic [7:0] rd_q [5];
  logic [7:0] qa2_q, qb2_q;
  logic [31:0] xc2_q;
  logic ok2_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      logic [7:0] v, qa, qb;
      logic [7:0] t [5];
      v  = gf_inv(rc_q[2]);
      qa = gf_mul(rb_q[1], v);
      t[0] = rb_q[0];
      for (int i = 1; i < 4; i++) t[i] = gf_mul(rc_q[i+1], qa) ^ rb_q[i];
      t[4] = rb_q[4];
      qb = gf_mul(v, t[2]);
      for (int i = 0; i < 5; i++) rd_q[i] <= t[i] ^ gf_mul(rc_q[i], qb);
      rc2_q <= rc_q;
      qa2_q <= qa;
      qb2_q <= qb;
      xc2_q <= xc_q;
      ok2_q <= ok1_q && (rc_q[2] != 8'h00);
    end
  end

  // Stage 3: round two auxiliary word.
  logic [7:0] rc3_q [5];
  logic [7:0] rd3_q [5];
  logic [31:0] xc3_q, xd_q;
  logic ok3_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      xd_q  <= aux_next(qa2_q, qb2_q, xc2_q, 32'h0000_0001);
      rc3_q <= rc2_q;
      rd3_q <= rd_q;
      xc3_q <= xc2_q;
      ok3_q <= ok2_q && (rd_q[3] != 8'h00);
    end
  end

  // Stage 4: round three quotient and last remainder constant.
  logic [7:0] qa4_q, qb4_q, re4_q, rd44_q, rd43_q;
  logic [31:0] xc4_q, xd4_q;
  logic ok4_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      logic [7:0] v, qa, qb, t3;
      v  = gf_inv(rd3_q[3]);
      qa = gf_mul(rc3_q[2], v);
      t3 = gf_mul(rd3_q[4], qa) ^ rc3_q[3];
      qb = gf_mul(v, t3);
      re4_q  <= rc3_q[4] ^ gf_mul(rd3_q[4], qb);
      qa4_q  <= qa;
      qb4_q  <= qb;
      rd43_q <= rd3_q[3];
      rd44_q <= rd3_q[4];
      xc4_q  <= xc3_q;
      xd4_q  <= xd_q;
      ok4_q  <= ok3_q;
    end
  end

  // Stage 5: round three auxiliary word and round four quotient.
  logic [7:0] qa5_q, qb5_q;
  logic [31:0] xd5_q, xe_q;
  logic ok5_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      logic [7:0] v;
      v = gf_inv(re4_q);
      xe_q  <= aux_next(qa4_q, qb4_q, xd4_q, xc4_q);
      qa5_q <= gf_mul(v, rd43_q);
      qb5_q <= gf_mul(v, rd44_q ^ 8'h01);
      xd5_q <= xd4_q;
      ok5_q <= ok4_q && (re4_q != 8'h00);
    end
  end

  // Stage 6: final auxiliary word is the inverse; this is the output register.
  logic [31:0] inv_q;
  logic ok6_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      inv_q <= ok5_q ? aux_next(qa5_q, qb5_q, xe_q, xd5_q) : 32'h0000_0000;
      ok6_q <= ok5_q;
    end
  end

  assign out_valid_o    = vld_q[NStg-1];
  assign inverse_word_o = inv_q;
  assign invertible_o   = ok6_q;

`ifndef SYNTHESIS
  // A non-invertible beat must carry a zero inverse.
  a_zero_when_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !invertible_o |-> inverse_word_o == 32'h0000_0000)
    else $error("non-invertible beat with nonzero inverse");
  // A stalled output beat holds its payload.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(inverse_word_o)
      && $stable(invertible_o))
    else $error("output beat changed while stalled");
  // An accepted input beat enters the first pipeline stage on the next cycle.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[0])
    else $error("accepted beat did not enter the pipeline");
`endif

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for gf256_word_poly_inverse
// Random and directed polynomial words are sent through a valid/ready driver
// while a monitor checks every output beat against a local predictor of the
// four-round extended-Euclid inverse modulo x^4+1. Both sides stall at random.
// ----------------------------------------------------------------------------
module testbench;

  // Bytes of a word: index 0 is the x^3 coefficient (top byte).
  typedef logic [0:3][7:0] coef_word_t;
  // Remainders: index 0 is x^4, index 4 the constant.
  typedef logic [0:4][7:0] rem_t;

  typedef struct packed {
    logic [31:0] inverse_word;
    logic        invertible;
  } inv_result_t;

  localparam int unsigned RandomItems = 1550;
  localparam int unsigned CalmTail    = 200;
  localparam int unsigned CycleLimit  = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] poly_word_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] inverse_word_o;
  logic        invertible_o;

  logic [31:0]  pending_words[$];
  inv_result_t  expected_inverses[$];
  logic [7:0]   byte_recip[256];
  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count = 0;
  logic         in_fired = 1'b0;
  int unsigned  send_gap = 0;
  int unsigned  recv_gap = 0;
  logic         filling_done = 1'b0;

  always #1 clk_i = ~clk_i;

  gf256_word_poly_inverse u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .poly_word_i    (poly_word_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .inverse_word_o (inverse_word_o),
    .invertible_o   (invertible_o)
  );

  // Shift-and-add product in GF(2^8) with the AES reduction polynomial.
  function automatic logic [7:0] field_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] sh;
    acc = '0;
    sh  = a;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) acc ^= sh;
      sh = sh[7] ? ((sh << 1) ^ 8'h1b) : (sh << 1);
    end
    return acc;
  endfunction

  // Next auxiliary word: (qx*x + q1) times prev modulo x^4+1, plus older.
  // Multiplying by x rotates the coefficients toward the top byte.
  function automatic coef_word_t next_aux(input logic [7:0] qx, input logic [7:0] q1,
                                          input coef_word_t prev, input coef_word_t older);
    coef_word_t d;
    for (int i = 0; i < 4; i++) begin
      d[i] = field_mul(qx, prev[(i + 1) % 4]) ^ field_mul(q1, prev[i]) ^ older[i];
    end
    return d;
  endfunction

  function automatic inv_result_t predict_inverse(input logic [31:0] w);
    rem_t       ra, rb, rc, rd, t;
    coef_word_t xb, xc, xd, xe, xf;
    logic [7:0] qa, qb, v, re4;
    logic       ok;
    inv_result_t r;
    ra = {8'h01, 8'h00, 8'h00, 8'h00, 8'h01};
    rb = {8'h00, w};
    xb = 32'h0000_0001;

    // Round one divides x^4+1 by the input; a zero top byte is not guarded.
    qa = byte_recip[rb[1]];
    t  = ra;
    for (int i = 0; i < 4; i++) t[i] = field_mul(qa, rb[i + 1]) ^ ra[i];
    qb = field_mul(qa, t[1]);
    for (int i = 0; i < 5; i++) rc[i] = t[i] ^ field_mul(qb, rb[i]);
    xc = {8'h00, 8'h00, qa, qb};
    ok = (rc[2] != 0);

    // Round two divides the input by the first remainder.
    v  = byte_recip[rc[2]];
    qa = field_mul(rb[1], v);
    t  = rb;
    for (int i = 1; i < 4; i++) t[i] = field_mul(rc[i + 1], qa) ^ rb[i];
    qb = field_mul(v, t[2]);
    for (int i = 0; i < 5; i++) rd[i] = t[i] ^ field_mul(rc[i], qb);
    xd = next_aux(qa, qb, xc, xb);
    ok = ok && (rd[3] != 0);

    // Round three only needs the constant of its remainder.
    v    = byte_recip[rd[3]];
    qa   = field_mul(rc[2], v);
    t[3] = field_mul(rd[4], qa) ^ rc[3];
    qb   = field_mul(v, t[3]);
    re4  = rc[4] ^ field_mul(rd[4], qb);
    xe   = next_aux(qa, qb, xd, xc);
    ok   = ok && (re4 != 0);

    // Round four forces the last remainder to one.
    v  = byte_recip[re4];
    qa = field_mul(v, rd[3]);
    qb = field_mul(v, rd[4] ^ 8'h01);
    xf = next_aux(qa, qb, xe, xd);

    r.inverse_word = ok ? xf : 32'h0;
    r.invertible   = ok;
    return r;
  endfunction

  // Random word with each byte possibly forced to zero, 0x01 or 0xff, so that
  // the zero-coefficient paths are hit far more often than by plain chance.
  function automatic logic [31:0] shaped_word();
    logic [31:0] w;
    w = $urandom;
    for (int i = 0; i < 4; i++) begin
      case ($urandom_range(0, 7))
        0: w[8*i +: 8] = 8'h00;
        1: w[8*i +: 8] = 8'hff;
        2: w[8*i +: 8] = 8'h01;
        default: ;
      endcase
    end
    return w;
  endfunction

  initial begin
    logic [31:0] w;
    int unsigned found;
    inv_result_t probe;
    // Reciprocal table by search; zero maps to zero.
    for (int a = 0; a < 256; a++) begin
      byte_recip[a] = 8'h00;
      for (int c = 1; c < 256; c++) begin
        if (field_mul(8'(a), 8'(c)) == 8'h01) byte_recip[a] = 8'(c);
      end
    end

    // Directed part: extremes, the identity, single terms, zero top byte.
    pending_words.push_back(32'h0000_0000);
    pending_words.push_back(32'hffff_ffff);
    pending_words.push_back(32'h0000_0001);
    pending_words.push_back(32'h0000_0100);
    pending_words.push_back(32'h0001_0000);
    pending_words.push_back(32'h0100_0000);
    pending_words.push_back(32'h0101_0101);
    pending_words.push_back(32'h0001_0001);
    pending_words.push_back(32'h8080_8080);
    pending_words.push_back(32'h00ff_ffff);
    pending_words.push_back(32'h0012_3456);
    pending_words.push_back(32'h0300_0102);
    pending_words.push_back(32'h0201_0103);
    pending_words.push_back(32'h5555_5555);
    pending_words.push_back(32'haaaa_aaaa);
    // A few words that fail one of the zero-divisor checks, found at random.
    found = 0;
    for (int tries = 0; tries < 200000 && found < 8; tries++) begin
      w = shaped_word();
      probe = predict_inverse(w);
      if (!probe.invertible) begin
        pending_words.push_back(w);
        found++;
      end
    end

    // Random part: mostly uniform words, some with shaped bytes.
    for (int n = 0; n < RandomItems; n++) begin
      pending_words.push_back(($urandom_range(0, 2) == 0) ? shaped_word() : $urandom);
    end
    filling_done = 1'b1;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (pending_words.size() == 0 && !in_valid_i && expected_inverses.size() == 0);
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Cycle counter and timeout.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Input acceptance: record the expectation for every accepted beat.
  always @(posedge clk_i) begin
    in_fired <= in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) begin
      expected_inverses.push_back(predict_inverse(poly_word_i));
    end
  end

  // Driver: changes inputs at the falling edge. A beat stays up until taken.
  always @(negedge clk_i) begin
    logic        nxt_valid;
    logic [31:0] nxt_word;
    logic        calm;
    nxt_valid = in_valid_i;
    nxt_word  = poly_word_i;
    calm      = filling_done && (pending_words.size() < CalmTail);
    if (rst_ni && (!in_valid_i || in_fired)) begin
      nxt_valid = 1'b0;
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        send_gap <= $urandom_range(1, 15) - 1;
      end else if (pending_words.size() > 0) begin
        nxt_valid = 1'b1;
        nxt_word  = pending_words.pop_front();
      end
    end
    in_valid_i  <= nxt_valid;
    poly_word_i <= nxt_word;
  end

  // Receiver back-pressure in bursts, none in the calm tail.
  always @(negedge clk_i) begin
    logic nxt_ready;
    nxt_ready = 1'b1;
    if (recv_gap > 0) begin
      recv_gap  <= recv_gap - 1;
      nxt_ready = 1'b0;
    end else if (!(filling_done && pending_words.size() < CalmTail) &&
                 $urandom_range(0, 9) == 0) begin
      recv_gap  <= $urandom_range(1, 15) - 1;
      nxt_ready = 1'b0;
    end
    out_ready_i <= nxt_ready;
  end

  // Monitor: every output beat is checked against the oldest expectation.
  always @(posedge clk_i) begin
    inv_result_t exp_res;
    logic        bad;
    bad = 1'b0;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_inverses.size() == 0) begin
        $error("output beat with no expectation: inverse_word %h invertible %b",
               inverse_word_o, invertible_o);
        bad = 1'b1;
      end else begin
        exp_res = expected_inverses.pop_front();
        if (inverse_word_o !== exp_res.inverse_word) begin
          $error("inverse_word: expected %h, actual %h", exp_res.inverse_word,
                 inverse_word_o);
          bad = 1'b1;
        end
        if (invertible_o !== exp_res.invertible) begin
          $error("invertible: expected %b, actual %b", exp_res.invertible, invertible_o);
          bad = 1'b1;
        end
      end
    end
    if (bad) begin
      mismatch_count <= mismatch_count + 1;
    end
  end

endmodule
